[design/wfpd_pkg.sv]
package wfpd_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W = 12;
   localparam int DUTY_W   = 7;
   localparam int Q_W      = 16;
   localparam int VOLT_W   = 18;
   localparam int VSQ_W    = 20;
   localparam int DIFF_W   = 22;
   localparam int MUL_W    = 24;
   localparam int PROD_W   = 48;
   localparam int STEP_W   = 5;
   localparam int ADDR_W   = 5;
   localparam int CSR_W    = 32;

   // Conversion and control constants, Q16 unless noted.
   localparam logic signed [MUL_W-1:0]  VOLT_SCALE = 24'sd216269;
   localparam logic signed [MUL_W-1:0]  COEF_A     = 24'sd332169;
   localparam logic signed [MUL_W-1:0]  COEF_B     = 24'sd1528889;
   localparam logic signed [PROD_W-1:0] COEF_C_Q32 = 48'sd2041578 <<< 16;
   localparam logic signed [MUL_W-1:0]  STEP_Q16   = 24'sd3277;
   localparam logic signed [17:0]       INTEG_LIMIT = 18'sd25600;

   localparam logic [DUTY_W-1:0] DUTY_HIGH_LIMIT = 7'd80;
   localparam logic [DUTY_W-1:0] DUTY_HIGH_VALUE = 7'd98;
   localparam logic [DUTY_W-1:0] DUTY_LOW_LIMIT  = 7'd20;
   localparam logic [DUTY_W-1:0] TURN_RIGHT_DUTY = 7'd30;
   localparam logic [DUTY_W-1:0] TURN_LEFT_DUTY  = 7'd80;

   // Register map and reset values.
   localparam logic [2:0] REG_TARGET = 3'd0;
   localparam logic [2:0] REG_KP     = 3'd1;
   localparam logic [2:0] REG_KI     = 3'd2;
   localparam logic [2:0] REG_KD     = 3'd3;
   localparam logic [2:0] REG_BASE   = 3'd4;

   localparam logic [Q_W-1:0]    TARGET_RESET = 16'd2560;
   localparam logic [Q_W-1:0]    KP_RESET     = 16'd307;
   localparam logic [Q_W-1:0]    KI_RESET     = 16'd128;
   localparam logic [Q_W-1:0]    KD_RESET     = 16'd64;
   localparam logic [DUTY_W-1:0] BASE_RESET   = 7'd98;

   // Microcode fields.
   typedef enum logic [2:0] {
      MA_VSCALE, MA_VOLT, MA_COEF_A, MA_COEF_B, MA_STEP, MA_KP, MA_KI, MA_KD
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_SAMPLE, MB_VOLT, MB_VSQ, MB_ERR, MB_INTEG, MB_DIFF
   } mul_b_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_VOLT, OP_VSQ, OP_ACC_INIT, OP_ACC_ADD, OP_ACC_SUB, OP_ACC_LOAD,
      OP_DIST, OP_ERROR, OP_DIFF, OP_INTEG, OP_DUTY_R, OP_DUTY_L, OP_TURN, OP_DONE
   } op_type;

   typedef enum logic [1:0] {
      JMP_NONE, JMP_TURN, JMP_ALWAYS
   } jump_type;

   typedef struct packed {
      mul_a_type         a_sel;
      mul_b_type         b_sel;
      op_type            op;
      jump_type          jmp;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] TURN_STEP = 5'd17;
   localparam logic [STEP_W-1:0] DONE_STEP = 5'd18;
   localparam logic [STEP_W-1:0] NO_STEP   = 5'd0;

   // The control program. A product selected in one step is read in the next.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type uc;
      unique case (addr)
         5'd0:  uc = '{MA_VSCALE, MB_SAMPLE, OP_NOP,      JMP_NONE,   NO_STEP};
         5'd1:  uc = '{MA_VSCALE, MB_SAMPLE, OP_VOLT,     JMP_NONE,   NO_STEP};
         5'd2:  uc = '{MA_VOLT,   MB_VOLT,   OP_ACC_INIT, JMP_NONE,   NO_STEP};
         5'd3:  uc = '{MA_VOLT,   MB_VOLT,   OP_VSQ,      JMP_NONE,   NO_STEP};
         5'd4:  uc = '{MA_COEF_A, MB_VSQ,    OP_NOP,      JMP_NONE,   NO_STEP};
         5'd5:  uc = '{MA_COEF_B, MB_VOLT,   OP_ACC_ADD,  JMP_NONE,   NO_STEP};
         5'd6:  uc = '{MA_COEF_B, MB_VOLT,   OP_ACC_SUB,  JMP_NONE,   NO_STEP};
         5'd7:  uc = '{MA_STEP,   MB_ERR,    OP_DIST,     JMP_NONE,   NO_STEP};
         5'd8:  uc = '{MA_STEP,   MB_ERR,    OP_ERROR,    JMP_NONE,   NO_STEP};
         5'd9:  uc = '{MA_STEP,   MB_ERR,    OP_DIFF,     JMP_TURN,   TURN_STEP};
         5'd10: uc = '{MA_STEP,   MB_ERR,    OP_INTEG,    JMP_NONE,   NO_STEP};
         5'd11: uc = '{MA_KP,     MB_ERR,    OP_NOP,      JMP_NONE,   NO_STEP};
         5'd12: uc = '{MA_KI,     MB_INTEG,  OP_ACC_LOAD, JMP_NONE,   NO_STEP};
         5'd13: uc = '{MA_KD,     MB_DIFF,   OP_ACC_ADD,  JMP_NONE,   NO_STEP};
         5'd14: uc = '{MA_KD,     MB_DIFF,   OP_ACC_ADD,  JMP_NONE,   NO_STEP};
         5'd15: uc = '{MA_KD,     MB_DIFF,   OP_DUTY_R,   JMP_NONE,   NO_STEP};
         5'd16: uc = '{MA_KD,     MB_DIFF,   OP_DUTY_L,   JMP_ALWAYS, DONE_STEP};
         5'd17: uc = '{MA_KD,     MB_DIFF,   OP_TURN,     JMP_NONE,   NO_STEP};
         default: uc = '{MA_KD,   MB_DIFF,   OP_DONE,     JMP_NONE,   NO_STEP};
      endcase
      return uc;
   endfunction

   // Q16.16 sum to a whole percent, truncated toward zero, then clamped.
   function automatic logic [DUTY_W-1:0] duty_of(input logic signed [PROD_W-1:0] sum);
      logic signed [PROD_W-1:0] mag;
      logic signed [PROD_W-1:0] quo;
      logic [DUTY_W-1:0]        duty;
      mag = -sum;
      quo = sum[PROD_W-1] ? -(mag >>> 16) : (sum >>> 16);
      if (quo > $signed({41'd0, DUTY_HIGH_LIMIT})) begin
         duty = DUTY_HIGH_VALUE;
      end else if (quo < $signed({41'd0, DUTY_LOW_LIMIT})) begin
         duty = DUTY_LOW_LIMIT;
      end else begin
         duty = quo[DUTY_W-1:0];
      end
      return duty;
   endfunction

endpackage

[design/wall_follow_pid_drive.sv]
// Channel   Direction  Handshake           Payload
// req       in         req_tvalid/tready   tdata[11:0] sensor_sample
// rsp       out        rsp_tvalid/tready   tdata: right, left duty, distance, error;
//                                          tuser: turn_override
// csr       in         APB, pready high    five control registers at 4*index
//
// A request is taken when the sequencer is idle; the microcode program then runs one
// step per cycle through a single shared 24x24 multiplier: 12 steps on the fixed right
// turn and 18 on the PID path. The result waits in an output register while the next
// request runs; the sequencer stalls in its final step only if the previous result is
// still untaken.
// Reset is synchronous and restores the register defaults and clears the PID state.
module wall_follow_pid_drive (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [11:0] sensor_sample, [15:12] zero

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [6:0] right_duty, [13:7] left_duty,
                                     // [29:14] distance_cm, [45:30] error_value,
                                     // [47:46] zero
   output logic [0:0]  rsp_tuser,    // [0] turn_override

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [wfpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [wfpd_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [wfpd_pkg::CSR_W-1:0]  csr_prdata,
   output logic                      csr_pready
);
   import wfpd_pkg::*;

   // Control registers.
   logic [Q_W-1:0]    target_ff, target_in;
   logic [Q_W-1:0]    kp_ff, kp_in;
   logic [Q_W-1:0]    ki_ff, ki_in;
   logic [Q_W-1:0]    kd_ff, kd_in;
   logic [DUTY_W-1:0] base_ff, base_in;

   // Sequencer.
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;
   op_type            op;
   logic              jump_taken;
   logic              done_fire;
   logic              req_fire;

   // Datapath.
   logic [SAMPLE_W-1:0]       sample_ff, sample_in;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic [VOLT_W-1:0]         volt_ff, volt_in;
   logic [VSQ_W-1:0]          vsq_ff, vsq_in;
   logic [Q_W-1:0]            dist_ff, dist_in;
   logic signed [Q_W-1:0]     err_ff, err_in;
   logic                      turn_ff, turn_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [Q_W-1:0]     integ_ff, integ_in;
   logic signed [Q_W-1:0]     last_ff, last_in;
   logic signed [Q_W-1:0]     esum_ff, esum_in;
   logic [DUTY_W-1:0]         rd_ff, rd_in;
   logic [DUTY_W-1:0]         ld_ff, ld_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // Scratch values for the datapath operations.
   logic signed [PROD_W-1:0] round_t;
   logic signed [PROD_W-1:0] prod_mag;
   logic signed [PROD_W-1:0] inc_t;
   logic signed [PROD_W-1:0] base_q;
   logic signed [16:0]       err_wide;
   logic signed [16:0]       err_step;
   logic signed [DIFF_W-1:0] step_ext;
   logic signed [17:0]       integ_sum;

   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   // Register writes; addresses past the last register are dropped.
   always_comb begin
      target_in = target_ff;
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      kd_in     = kd_ff;
      base_in   = base_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_TARGET: target_in = csr_pwdata[Q_W-1:0];
            REG_KP:     kp_in     = csr_pwdata[Q_W-1:0];
            REG_KI:     ki_in     = csr_pwdata[Q_W-1:0];
            REG_KD:     kd_in     = csr_pwdata[Q_W-1:0];
            REG_BASE:   base_in   = csr_pwdata[DUTY_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_TARGET: csr_prdata = {16'd0, target_ff};
         REG_KP:     csr_prdata = {16'd0, kp_ff};
         REG_KI:     csr_prdata = {16'd0, ki_ff};
         REG_KD:     csr_prdata = {16'd0, kd_ff};
         REG_BASE:   csr_prdata = {25'd0, base_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Step counter: restart at step zero on an accepted request, advance, take a jump,
   // or wait in the final step for the output register to free up.
   assign uc         = ucode_rom(step_ff);
   assign op         = busy_ff ? uc.op : OP_NOP;
   assign req_tready = ~busy_ff;
   assign req_fire   = req_tvalid & ~busy_ff;
   assign done_fire  = (op == OP_DONE) && (!rsp_valid_ff || rsp_tready);
   assign jump_taken = (uc.jmp == JMP_ALWAYS) || ((uc.jmp == JMP_TURN) && turn_ff);

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      sample_in = sample_ff;
      if (!busy_ff) begin
         if (req_fire) begin
            busy_in   = 1'b1;
            step_in   = '0;
            sample_in = req_tdata[SAMPLE_W-1:0];
         end
      end else if (uc.op == OP_DONE) begin
         if (done_fire) begin
            busy_in = 1'b0;
         end
      end else if (jump_taken) begin
         step_in = uc.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // Shared multiplier operands; the product is registered every cycle.
   always_comb begin
      unique case (uc.a_sel)
         MA_VSCALE: mul_a = VOLT_SCALE;
         MA_VOLT:   mul_a = $signed({6'd0, volt_ff});
         MA_COEF_A: mul_a = COEF_A;
         MA_COEF_B: mul_a = COEF_B;
         MA_STEP:   mul_a = STEP_Q16;
         MA_KP:     mul_a = $signed({8'd0, kp_ff});
         MA_KI:     mul_a = $signed({8'd0, ki_ff});
         MA_KD:     mul_a = $signed({8'd0, kd_ff});
         default:   mul_a = '0;
      endcase
      unique case (uc.b_sel)
         MB_SAMPLE: mul_b = $signed({12'd0, sample_ff});
         MB_VOLT:   mul_b = $signed({6'd0, volt_ff});
         MB_VSQ:    mul_b = $signed({4'd0, vsq_ff});
         MB_ERR:    mul_b = $signed({{8{err_ff[Q_W-1]}}, err_ff});
         MB_INTEG:  mul_b = $signed({{8{integ_ff[Q_W-1]}}, integ_ff});
         MB_DIFF:   mul_b = $signed({{2{diff_ff[DIFF_W-1]}}, diff_ff});
         default:   mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign base_q  = $signed({25'd0, base_ff, 16'd0});

   // Datapath operations, one per control word.
   always_comb begin
      acc_in   = acc_ff;
      volt_in  = volt_ff;
      vsq_in   = vsq_ff;
      dist_in  = dist_ff;
      err_in   = err_ff;
      turn_in  = turn_ff;
      diff_in  = diff_ff;
      integ_in = integ_ff;
      last_in  = last_ff;
      esum_in  = esum_ff;
      rd_in    = rd_ff;
      ld_in    = ld_ff;

      round_t  = '0;
      prod_mag = -prod_ff;
      inc_t    = '0;
      err_wide = $signed({1'b0, target_ff}) - $signed({1'b0, dist_ff});
      err_step = $signed({err_ff[Q_W-1], err_ff}) - $signed({last_ff[Q_W-1], last_ff});
      step_ext = $signed({{5{err_step[16]}}, err_step});
      integ_sum = '0;

      case (op)
         OP_VOLT: begin
            // Volts in Q16, rounded.
            round_t = prod_ff + 48'sd2048;
            volt_in = round_t[29:12];
         end
         OP_VSQ: begin
            round_t = prod_ff + 48'sd32768;
            vsq_in  = round_t[35:16];
         end
         OP_ACC_INIT: acc_in = COEF_C_Q32;
         OP_ACC_ADD:  acc_in = acc_ff + prod_ff;
         OP_ACC_SUB:  acc_in = acc_ff - prod_ff;
         OP_ACC_LOAD: acc_in = prod_ff;
         OP_DIST: begin
            // Q32 polynomial to Q8.8 centimetres, floored at zero, capped at full scale.
            round_t = acc_ff + 48'sd8388608;
            if (acc_ff[PROD_W-1]) begin
               dist_in = '0;
            end else if (|round_t[47:40]) begin
               dist_in = '1;
            end else begin
               dist_in = round_t[39:24];
            end
         end
         OP_ERROR: begin
            if (err_wide[16] != err_wide[15]) begin
               err_in = err_wide[16] ? 16'sh8000 : 16'sh7fff;
            end else begin
               err_in = err_wide[15:0];
            end
            turn_in = dist_ff > target_ff;
         end
         OP_DIFF: begin
            // Change in error times the 20 Hz step rate.
            diff_in = (step_ext <<< 4) + (step_ext <<< 2);
         end
         OP_INTEG: begin
            // Error times 0.05, rounded half away from zero, added to the error sum, then clamped.
            if (prod_ff[PROD_W-1]) begin
               inc_t = -((prod_mag + 48'sd32768) >>> 16);
            end else begin
               inc_t = (prod_ff + 48'sd32768) >>> 16;
            end
            integ_sum = $signed({{2{esum_ff[Q_W-1]}}, esum_ff}) + inc_t[17:0];
            if (integ_sum > INTEG_LIMIT) begin
               integ_in = INTEG_LIMIT[Q_W-1:0];
            end else if (integ_sum < -INTEG_LIMIT) begin
               integ_in = 16'(-INTEG_LIMIT);
            end else begin
               integ_in = integ_sum[Q_W-1:0];
            end
         end
         OP_DUTY_R: rd_in = duty_of(base_q + acc_ff);
         OP_DUTY_L: begin
            ld_in   = duty_of(base_q - acc_ff);
            esum_in = integ_ff;
            last_in = err_ff;
         end
         OP_TURN: begin
            rd_in = TURN_RIGHT_DUTY;
            ld_in = TURN_LEFT_DUTY;
         end
         default: ;
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, err_ff, dist_ff, ld_ff, rd_ff};
         rsp_user_in  = turn_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RESET;
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         kd_ff        <= KD_RESET;
         base_ff      <= BASE_RESET;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         last_ff      <= '0;
         esum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         base_ff      <= base_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         esum_ff      <= esum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      volt_ff     <= volt_in;
      vsq_ff      <= vsq_in;
      dist_ff     <= dist_in;
      err_ff      <= err_in;
      turn_ff     <= turn_in;
      diff_ff     <= diff_in;
      integ_ff    <= integ_in;
      rd_ff       <= rd_in;
      ld_ff       <= ld_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

[bench/tb.sv]
module tb;

   // Register byte addresses: register index times four.
   localparam logic [4:0] CSR_TARGET    = {wfpd_pkg::REG_TARGET, 2'b00};
   localparam logic [4:0] CSR_KP        = {wfpd_pkg::REG_KP, 2'b00};
   localparam logic [4:0] CSR_KI        = {wfpd_pkg::REG_KI, 2'b00};
   localparam logic [4:0] CSR_KD        = {wfpd_pkg::REG_KD, 2'b00};
   localparam logic [4:0] CSR_BASE      = {wfpd_pkg::REG_BASE, 2'b00};
   localparam logic [4:0] CSR_UNUSED_LO = 5'd20;
   localparam logic [4:0] CSR_UNUSED_HI = 5'd28;

   // Fixed-point constants of the sensor curve and the control loop.
   localparam longint VOLT_Q16      = 216269;
   localparam longint CURVE_A_Q16   = 332169;
   localparam longint CURVE_B_Q16   = 1528889;
   localparam longint CURVE_C_Q16   = 2041578;
   localparam longint STEP_TIME_Q16 = 3277;
   localparam longint DERIV_RATE    = 20;
   localparam longint INTEG_CLAMP   = 25600;
   localparam longint DUTY_CEILING  = 80;
   localparam longint DUTY_FULL     = 98;
   localparam longint DUTY_FLOOR    = 20;
   localparam logic [6:0] TURN_RIGHT_PCT = 7'd30;
   localparam logic [6:0] TURN_LEFT_PCT  = 7'd80;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 24;
   localparam int MAX_GAP         = 12;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int CYCLE_LIMIT     = 600000;

   typedef struct packed {
      logic [6:0]  right_duty;
      logic [6:0]  left_duty;
      logic        turn_override;
      logic [15:0] distance_cm;
      logic [15:0] error_value;
   } drive_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [4:0]   addr;
      logic [31:0]  wdata;
      logic [15:0]  tdata;
      bit           typed;
      drive_type    result;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [11:0] sensor_sample, [15:12] zero

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [6:0] right_duty, [13:7] left_duty,
                                   // [29:14] distance_cm, [45:30] error_value
   logic [0:0]  rsp_tuser;         // [0] turn_override

   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [wfpd_pkg::ADDR_W-1:0]      csr_paddr = '0;
   logic [wfpd_pkg::CSR_W-1:0]       csr_pwdata = '0;
   logic [wfpd_pkg::CSR_W-1:0]       csr_prdata;
   logic                             csr_pready;

   // Shadow copy of the control registers and the loop state.
   logic [15:0]        target_cm  = wfpd_pkg::TARGET_RESET;
   logic [15:0]        kp_gain    = wfpd_pkg::KP_RESET;
   logic [15:0]        ki_gain    = wfpd_pkg::KI_RESET;
   logic [15:0]        kd_gain    = wfpd_pkg::KD_RESET;
   logic [6:0]         base_pct   = wfpd_pkg::BASE_RESET;
   logic signed [15:0] err_last   = '0;
   logic signed [15:0] error_sum  = '0;

   drive_type pending_drives[$];
   int     mismatch_count = 0;
   int     cycle_count = 0;
   bit     req_gaps = 1'b1;
   bit     rsp_stalls = 1'b1;

   wall_follow_pid_drive dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A Q16.16 drive sum to a whole percent, truncated toward zero, then the
   // high duty snaps to full drive and the low duty is held at the floor.
   function automatic logic [6:0] percent_of(input longint sum_q16);
      longint pct;
      pct = sum_q16 / 65536;
      if (pct > DUTY_CEILING) pct = DUTY_FULL;
      if (pct < DUTY_FLOOR) pct = DUTY_FLOOR;
      return pct[6:0];
   endfunction

   // Works out the wheel drive for one sensor reading and advances the
   // loop state when the PID path is taken.
   function automatic drive_type predict_drive(input logic [11:0] sample);
      longint volts, volts_sq, curve, dist_q8, err, step, integ, adj, base_q16;
      drive_type r;
      volts    = (longint'(sample) * VOLT_Q16 + 2048) >>> 12;
      volts_sq = (volts * volts + 32768) >>> 16;
      curve    = CURVE_A_Q16 * volts_sq - CURVE_B_Q16 * volts + (CURVE_C_Q16 <<< 16);
      if (curve < 0) begin
         dist_q8 = 0;
      end else begin
         dist_q8 = (curve + (longint'(1) <<< 23)) >>> 24;
         if (dist_q8 > 65535) dist_q8 = 65535;
      end
      err = longint'(target_cm) - dist_q8;
      if (err > 32767) err = 32767;
      if (err < -32768) err = -32768;
      r.distance_cm = dist_q8[15:0];
      r.error_value = err[15:0];
      if (dist_q8 > longint'(target_cm)) begin
         // Wall too far away: fixed right turn, loop state left alone.
         r.right_duty    = TURN_RIGHT_PCT;
         r.left_duty     = TURN_LEFT_PCT;
         r.turn_override = 1'b1;
      end else begin
         // Integral step is err * 0.05, rounded half away from zero.
         step = err * STEP_TIME_Q16;
         step = (step >= 0) ? (step + 32768) / 65536 : -((-step + 32768) / 65536);
         integ = longint'(error_sum) + step;
         if (integ > INTEG_CLAMP) integ = INTEG_CLAMP;
         if (integ < -INTEG_CLAMP) integ = -INTEG_CLAMP;
         adj = longint'(kp_gain) * err + longint'(ki_gain) * integ
             + longint'(kd_gain) * (err - longint'(err_last)) * DERIV_RATE;
         base_q16 = longint'(base_pct) * 65536;
         r.right_duty    = percent_of(base_q16 + adj);
         r.left_duty     = percent_of(base_q16 - adj);
         r.turn_override = 1'b0;
         error_sum = integ[15:0];
         err_last  = err[15:0];
      end
      return r;
   endfunction

   function automatic step_row_type sample_row(input logic [15:0] data);
      step_row_type row;
      row.kind   = ROW_SAMPLE;
      row.addr   = '0;
      row.wdata  = '0;
      row.tdata  = data;
      row.typed  = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic step_row_type known_row(input logic [15:0] data, input logic [6:0] rd,
                                              input logic [6:0] ld, input logic turn,
                                              input logic [15:0] dist_v,
                                              input logic [15:0] err);
      step_row_type row;
      row = sample_row(data);
      row.typed = 1'b1;
      row.result.right_duty    = rd;
      row.result.left_duty     = ld;
      row.result.turn_override = turn;
      row.result.distance_cm   = dist_v;
      row.result.error_value   = err;
      return row;
   endfunction

   function automatic step_row_type csr_row(input logic [4:0] addr, input logic [31:0] data);
      step_row_type row;
      row = sample_row('0);
      row.kind  = ROW_CSR;
      row.addr  = addr;
      row.wdata = data;
      return row;
   endfunction

   // Fills the bits above a 16-bit register with noise; the block masks them.
   function automatic logic [31:0] with_junk16(input logic [15:0] value);
      return ($urandom() & 32'hFFFF_0000) | {16'd0, value};
   endfunction

   function automatic logic [15:0] pick_gain();
      logic [15:0] g;
      case ($urandom_range(0, 5))
         0: g = 16'd0;
         1: g = 16'hFFFF;
         2: g = 16'($urandom_range(0, 65535));
         default: g = 16'($urandom_range(0, 1023));
      endcase
      return g;
   endfunction

   // APB write: setup cycle, access cycle, then psel is dropped before the next write
   // so that back-to-back writes never retime psel inside one step.
   task automatic csr_write(input logic [4:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (addr)
         CSR_TARGET: target_cm = data[15:0];
         CSR_KP:     kp_gain   = data[15:0];
         CSR_KI:     ki_gain   = data[15:0];
         CSR_KD:     kd_gain   = data[15:0];
         CSR_BASE:   base_pct  = data[6:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one sensor request after a random gap and records the drive it
   // should produce once the block accepts it.
   task automatic send_reading(input logic [15:0] data, input bit typed,
                               input drive_type typed_result);
      int        gap;
      drive_type predicted;
      gap = req_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_drive(data[11:0]);
      pending_drives.push_back(typed ? typed_result : predicted);
   endtask

   // Holds off new requests until every expected drive has come back and
   // the sequencer has had time to settle.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_drive();
      drive_type want;
      drive_type got;
      got.right_duty    = rsp_tdata[6:0];
      got.left_duty     = rsp_tdata[13:7];
      got.distance_cm   = rsp_tdata[29:14];
      got.error_value   = rsp_tdata[45:30];
      got.turn_override = rsp_tuser[0];
      if (pending_drives.size() == 0) begin
         $display("%0t: drive with nothing expected, expected none, actual tdata=0x%h tuser=%b",
                  $time, rsp_tdata, rsp_tuser);
         mismatch_count++;
      end else begin
         want = pending_drives.pop_front();
         compare_field("right_duty", 16'(want.right_duty), 16'(got.right_duty));
         compare_field("left_duty", 16'(want.left_duty), 16'(got.left_duty));
         compare_field("turn_override", 16'(want.turn_override), 16'(got.turn_override));
         compare_field("distance_cm", want.distance_cm, got.distance_cm);
         compare_field("error_value", want.error_value, got.error_value);
      end
   endtask

   // Result side: stall a random number of cycles before each drive, then
   // hold ready high until the handshake.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_stalls ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_drive();
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAILURE");
      $finish;
   end

   initial begin
      step_row_type rows[$];
      logic [15:0]  reading;
      logic [15:0]  target_w;
      logic [6:0]   base_w;
      int           p;
      int           n;

      // Sample zero reads 7975 (about 31.15 cm), which makes a few rows
      // easy to write down by hand.
      rows.push_back(known_row(16'h0000, 7'd30, 7'd80, 1'b1, 16'd7975, -16'sd5415));
      rows.push_back(sample_row(16'h0FFF));
      rows.push_back(sample_row(16'h0800));
      rows.push_back(sample_row(16'h0AAA));
      rows.push_back(sample_row(16'h0555));
      rows.push_back(sample_row(16'hFFFF));    // bits above the sample are ignored
      // Far set-point: error saturates and the PID drives full right, floor left.
      rows.push_back(csr_row(CSR_TARGET, 32'hFFFF_FFFF));
      rows.push_back(known_row(16'h0000, 7'd98, 7'd20, 1'b0, 16'd7975, 16'sd32767));
      rows.push_back(known_row(16'h0000, 7'd98, 7'd20, 1'b0, 16'd7975, 16'sd32767));
      rows.push_back(sample_row(16'h0FFF));
      // Zero set-point: every reading is beyond it, so the turn is forced.
      rows.push_back(csr_row(CSR_TARGET, 32'hFFFF_0000));
      rows.push_back(known_row(16'h0000, 7'd30, 7'd80, 1'b1, 16'd7975, -16'sd7975));
      rows.push_back(sample_row(16'h0800));
      // Zero gains: both duties follow the base duty through the clamps.
      rows.push_back(csr_row(CSR_TARGET, 32'h0000_FFFF));
      rows.push_back(csr_row(CSR_KP, 32'd0));
      rows.push_back(csr_row(CSR_KI, 32'd0));
      rows.push_back(csr_row(CSR_KD, 32'd0));
      rows.push_back(csr_row(CSR_BASE, 32'd50));
      rows.push_back(known_row(16'h0000, 7'd50, 7'd50, 1'b0, 16'd7975, 16'sd32767));
      rows.push_back(csr_row(CSR_BASE, 32'd0));
      rows.push_back(known_row(16'h0000, 7'd20, 7'd20, 1'b0, 16'd7975, 16'sd32767));
      rows.push_back(csr_row(CSR_BASE, 32'd100));
      rows.push_back(known_row(16'h0000, 7'd98, 7'd98, 1'b0, 16'd7975, 16'sd32767));
      // A base above 100 is taken as written and clamped like any other.
      rows.push_back(csr_row(CSR_BASE, 32'hFFFF_FFFF));
      rows.push_back(known_row(16'h0000, 7'd98, 7'd98, 1'b0, 16'd7975, 16'sd32767));
      // Writes past the last register must not land anywhere.
      rows.push_back(csr_row(CSR_UNUSED_LO, 32'd0));
      rows.push_back(csr_row(CSR_UNUSED_HI, 32'd0));
      rows.push_back(known_row(16'h0000, 7'd98, 7'd98, 1'b0, 16'd7975, 16'sd32767));
      // Full gains, set-point equal to the zero-sample distance: PID path.
      rows.push_back(csr_row(CSR_KP, 32'h0000_FFFF));
      rows.push_back(csr_row(CSR_KI, 32'h0000_FFFF));
      rows.push_back(csr_row(CSR_KD, 32'h0000_FFFF));
      rows.push_back(csr_row(CSR_BASE, 32'd98));
      rows.push_back(csr_row(CSR_TARGET, 32'd7975));
      rows.push_back(sample_row(16'h0000));
      rows.push_back(sample_row(16'h0FFF));
      rows.push_back(sample_row(16'h0000));
      rows.push_back(sample_row(16'h07FF));
      // Back to the reset settings before the random phases.
      rows.push_back(csr_row(CSR_TARGET, 32'(wfpd_pkg::TARGET_RESET)));
      rows.push_back(csr_row(CSR_KP, 32'(wfpd_pkg::KP_RESET)));
      rows.push_back(csr_row(CSR_KI, 32'(wfpd_pkg::KI_RESET)));
      rows.push_back(csr_row(CSR_KD, 32'(wfpd_pkg::KD_RESET)));
      rows.push_back(csr_row(CSR_BASE, 32'(wfpd_pkg::BASE_RESET)));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_for_idle();
            csr_write(rows[i].addr, rows[i].wdata);
         end else begin
            send_reading(rows[i].tdata, rows[i].typed, rows[i].result);
         end
      end

      // Random phases: new settings, then a long run of readings. Each phase
      // starts only after every expected drive has come back.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_idle();
         case ($urandom_range(0, 9))
            0: target_w = 16'd0;
            1: target_w = 16'hFFFF;
            2: target_w = 16'($urandom_range(0, 65535));
            default: target_w = 16'($urandom_range(1000, 8200));   // covers the sensor span with a margin
         endcase
         case ($urandom_range(0, 6))
            0: base_w = 7'd0;
            1: base_w = 7'd100;
            2: base_w = 7'd127;
            default: base_w = 7'($urandom_range(20, 100));
         endcase
         csr_write(CSR_TARGET, with_junk16(target_w));
         csr_write(CSR_KP, with_junk16(pick_gain()));
         csr_write(CSR_KI, with_junk16(pick_gain()));
         csr_write(CSR_KD, with_junk16(pick_gain()));
         csr_write(CSR_BASE, ($urandom() & 32'hFFFF_FF80) | {25'd0, base_w});
         if ($urandom_range(0, 3) == 0) begin
            csr_write(CSR_UNUSED_LO + 5'(4 * $urandom_range(0, 2)), $urandom());
         end
         req_gaps   = ($urandom_range(0, 3) != 0);
         rsp_stalls = ($urandom_range(0, 3) != 0);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 15))
               0: reading = 16'h0000;
               1: reading = 16'h0FFF;
               default: reading = 16'($urandom_range(0, 4095));
            endcase
            if ($urandom_range(0, 7) == 0) begin
               reading[15:12] = 4'($urandom_range(1, 15));
            end
            send_reading(reading, 1'b0, '0);
         end
      end

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
